[rtl/core/kpd_pkg.sv]
// Shared types, constants and key map for the keypad scanner.
package kpd_pkg;

  localparam int HISTORY_BITS_DEF = 8;
  localparam int KEY_ROWS_DEF     = 4;
  localparam int NUM_COLS         = 4;
  localparam int SAMPLED_ROWS     = 4;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic       op;
    logic [3:0] rows;
  } kpd_op_t;

  function automatic logic [6:0] key_ascii(input logic [3:0] idx);
    logic [6:0] ch;
    unique case (idx)
      4'd0:    ch = 7'h44; // D
      4'd1:    ch = 7'h43; // C
      4'd2:    ch = 7'h42; // B
      4'd3:    ch = 7'h41; // A
      4'd4:    ch = 7'h23; // #
      4'd5:    ch = 7'h39; // 9
      4'd6:    ch = 7'h36; // 6
      4'd7:    ch = 7'h33; // 3
      4'd8:    ch = 7'h30; // 0
      4'd9:    ch = 7'h38; // 8
      4'd10:   ch = 7'h35; // 5
      4'd11:   ch = 7'h32; // 2
      4'd12:   ch = 7'h2a; // *
      4'd13:   ch = 7'h37; // 7
      4'd14:   ch = 7'h34; // 4
      default: ch = 7'h31; // 1
    endcase
    return ch;
  endfunction

endpackage

[rtl/core/kpd_front.sv]
// Front end: accepts items, classifies them and queues them for the executor.
module kpd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cmd,
  input  logic [3:0]      row_bits,
  output logic            op_valid,
  input  logic            op_ready,
  output kpd_pkg::kpd_op_t op
);
  import kpd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  kpd_op_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;
  kpd_op_t            op_in;

  always_comb begin
    op_in.op   = (cmd == OP_READ) ? OP_READ : OP_SCAN;
    // rows only matter for a scan tick
    op_in.rows = (cmd == OP_READ) ? 4'd0 : row_bits;
  end

  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign op_valid = (count != '0);
  assign op       = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/kpd_exec.sv]
// Back end: debounce histories, press ring, key lookup and output register.
module kpd_exec #(
  parameter int HISTORY_BITS = kpd_pkg::HISTORY_BITS_DEF,
  parameter int KEY_ROWS     = kpd_pkg::KEY_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  output logic             op_ready,
  input  kpd_pkg::kpd_op_t op,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       column_drive,
  output logic             key_valid,
  output logic [3:0]       key_index,
  output logic [6:0]       key_char
);
  import kpd_pkg::*;

  localparam int NUM_KEYS = NUM_COLS * KEY_ROWS;
  localparam int IDX_W    = $clog2(NUM_KEYS);
  localparam int COL_W    = $clog2(NUM_COLS);

  typedef logic [HISTORY_BITS-1:0] hist_t;
  typedef hist_t [KEY_ROWS-1:0]    hist_col_t;

  hist_col_t        hist      [NUM_COLS];
  hist_col_t        col_next;
  logic [COL_W-1:0] scan_col;
  logic [COL_W-1:0] scan_col_next;
  logic             ring_vld  [2];
  logic [IDX_W-1:0] ring_idx  [2];
  logic             ring_vld_next [2];
  logic [IDX_W-1:0] ring_idx_next [2];
  logic             write_slot, write_slot_next;
  logic             read_slot, read_slot_next;
  logic             fire;

  logic             res_valid;
  logic [3:0]       res_index;
  logic [6:0]       res_char;
  logic [7:0]       idx_wide;

  assign op_ready = !out_valid || out_ready;
  assign fire     = op_valid && op_ready;

  always_comb begin
    hist_t      h;
    logic       bit_in;
    h               = '0;
    bit_in          = 1'b0;
    col_next        = hist[scan_col];
    scan_col_next   = scan_col;
    ring_vld_next   = ring_vld;
    ring_idx_next   = ring_idx;
    write_slot_next = write_slot;
    read_slot_next  = read_slot;
    res_valid       = 1'b0;
    res_index       = 4'd0;
    res_char        = 7'd0;
    idx_wide        = 8'(ring_idx[read_slot]);
    if (op.op == OP_SCAN) begin
      for (int r = 0; r < KEY_ROWS; r++) begin
        bit_in = (r < SAMPLED_ROWS) ? op.rows[r % SAMPLED_ROWS] : 1'b0;
        h = {hist[scan_col][r][HISTORY_BITS-2:0], bit_in};
        col_next[r] = h;
        // a single high after a run of lows is a new press; pushes go in row order
        if (h == hist_t'(1)) begin
          ring_vld_next[write_slot_next] = 1'b1;
          ring_idx_next[write_slot_next] = IDX_W'(KEY_ROWS * int'(scan_col) + r);
          write_slot_next                = !write_slot_next;
        end
      end
      scan_col_next = scan_col + 1'b1;
    end else if (ring_vld[read_slot]) begin
      res_valid                = 1'b1;
      res_index                = idx_wide[3:0];
      res_char                 = (idx_wide < 8'd16) ? key_ascii(idx_wide[3:0]) : 7'd0;
      ring_vld_next[read_slot] = 1'b0;
      ring_idx_next[read_slot] = '0;
      read_slot_next           = !read_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        hist[c] <= '0;
      end
      scan_col   <= '0;
      ring_vld   <= '{default: 1'b0};
      ring_idx   <= '{default: '0};
      write_slot <= 1'b0;
      read_slot  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        hist[scan_col] <= col_next;
        scan_col       <= scan_col_next;
        ring_vld       <= ring_vld_next;
        ring_idx       <= ring_idx_next;
        write_slot     <= write_slot_next;
        read_slot      <= read_slot_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      column_drive <= 4'(1) << scan_col_next;
      key_valid    <= res_valid;
      key_index    <= res_index;
      key_char     <= res_char;
    end
  end

endmodule

[rtl/core/keypad_scan_debounce_core.sv]
// Top level of the 4x4 keypad scanner and debouncer.
// Input channel (in_valid/in_ready): cmd selects a scan tick (row_bits holds
// the row levels of the column now driven) or a read of the next queued key.
// Output channel (out_valid/out_ready): one result item per input item, in
// order: column_drive (one-hot column to sample next), key_valid, key_index
// and key_char (ASCII from the fixed key map); the key fields are zero on a
// scan tick and on a read of an empty ring.
// Throughput is one item per cycle while the receiver keeps taking results;
// each item's state update is done by the executor's shift-and-compare per row.
// Each item lands in a two-entry queue at acceptance; the executor takes it
// from the queue, updates state and fills the output register. When the
// receiver stalls, the output register holds its item, the queue fills, and
// in_ready drops after two more items.
// Reset clears all key histories, the press ring and its slot pointers, the
// scan column and the queue; no result is pending afterwards.
module keypad_scan_debounce_core #(
  parameter int HISTORY_BITS = kpd_pkg::HISTORY_BITS_DEF,
  parameter int KEY_ROWS     = kpd_pkg::KEY_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cmd,
  input  logic [3:0] row_bits,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] column_drive,
  output logic       key_valid,
  output logic [3:0] key_index,
  output logic [6:0] key_char
);
  import kpd_pkg::*;

  kpd_op_t op;
  logic    op_valid;
  logic    op_ready;

  kpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .row_bits (row_bits),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  kpd_exec #(
    .HISTORY_BITS (HISTORY_BITS),
    .KEY_ROWS     (KEY_ROWS)
  ) u_exec (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (op_valid),
    .op_ready     (op_ready),
    .op           (op),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .column_drive (column_drive),
    .key_valid    (key_valid),
    .key_index    (key_index),
    .key_char     (key_char)
  );

endmodule

[dv/keypad_scan_debounce_core_tb.sv]
// Testbench for the keypad scanner core: directed and random items checked against a local model.
module keypad_scan_debounce_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;
  localparam int RANDOM_ITEMS   = 276;
  localparam int READ_PCT       = 35;
  // key legend, index 0 is the leftmost character
  localparam logic [127:0] KEY_LEGEND = "DCBA#9630852*741";

  typedef struct packed {
    logic [3:0] column_drive;
    logic       key_valid;
    logic [3:0] key_index;
    logic [6:0] key_char;
  } key_result_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic       cmd       = OP_SCAN;
  logic [3:0] row_bits  = 4'h0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] column_drive;
  logic       key_valid;
  logic [3:0] key_index;
  logic [6:0] key_char;

  // local copy of the scanner state
  logic [7:0]  key_hist [16];
  logic [1:0]  scan_col;
  logic [7:0]  press_slots [2];
  logic        push_ptr;
  logic        pop_ptr;
  logic [15:0] held_keys;

  key_result_t expected_results [$];

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int keys_predicted = 0;
  int empty_reads    = 0;
  int mismatches     = 0;
  int idle_streak    = 0;

  keypad_scan_debounce_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .row_bits     (row_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .column_drive (column_drive),
    .key_valid    (key_valid),
    .key_index    (key_index),
    .key_char     (key_char)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic clear_keypad_model();
    int k;
    for (k = 0; k < 16; k++) begin
      key_hist[k] = 8'h00;
    end
    press_slots[0] = 8'h00;
    press_slots[1] = 8'h00;
    scan_col  = 2'd0;
    push_ptr  = 1'b0;
    pop_ptr   = 1'b0;
    held_keys = 16'h0000;
  endtask

  function automatic key_result_t keypad_step(input logic op, input logic [3:0] rows);
    key_result_t r;
    logic [3:0]  k;
    logic [7:0]  slot;
    int          i;
    int          idx;
    r = '0;
    if (op == OP_SCAN) begin
      for (i = 0; i < 4; i++) begin
        k = 4'(int'(scan_col) * 4 + i);
        key_hist[k] = {key_hist[k][6:0], rows[i]};
        // exactly one high sample after a run of lows is a new press
        if (key_hist[k] == 8'd1) begin
          press_slots[push_ptr] = {4'b1000, k};
          push_ptr = ~push_ptr;
        end
      end
      scan_col = scan_col + 2'd1;
    end else begin
      slot = press_slots[pop_ptr];
      if (slot[7]) begin
        idx = int'(slot[3:0]);
        r.key_valid = 1'b1;
        r.key_index = slot[3:0];
        r.key_char  = KEY_LEGEND[8 * (15 - idx) +: 7];
        press_slots[pop_ptr] = 8'h00;
        pop_ptr = ~pop_ptr;
      end
    end
    r.column_drive = 4'b0001 << scan_col;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t ns  mismatch: %s", $time, what);
    end
  endtask

  task automatic send_item(input logic op, input logic [3:0] rows);
    key_result_t r;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    row_bits <= rows;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = keypad_step(op, rows);
    expected_results.push_back(r);
    items_sent++;
    if (r.key_valid) begin
      keys_predicted++;
    end else if (op == OP_READ) begin
      empty_reads++;
    end
  endtask

  // held keys drift slowly; taps and bounce flip single rows; some ticks are pure noise
  function automatic logic [3:0] pick_rows();
    logic [3:0] rows;
    int         pick;
    if ($urandom_range(99) < 4) begin
      held_keys[$urandom_range(15)] ^= 1'b1;
    end
    rows = held_keys[4 * scan_col +: 4];
    pick = $urandom_range(99);
    if (pick < 20) begin
      rows[$urandom_range(3)] ^= 1'b1;
    end else if (pick < 28) begin
      rows = 4'($urandom);
    end
    return rows;
  endfunction

  task automatic test_read_empty_ring();
    send_item(OP_READ, 4'h0);
    send_item(OP_READ, 4'hf);
  endtask

  // all sixteen keys see their first high sample: pushes overwrite the full ring
  task automatic test_full_matrix_press();
    repeat (4) send_item(OP_SCAN, 4'hf);
    repeat (3) send_item(OP_READ, 4'h0);
  endtask

  task automatic test_held_keys();
    repeat (4) send_item(OP_SCAN, 4'hf);
    send_item(OP_READ, 4'h5);
  endtask

  task automatic test_release_bounce();
    repeat (4) send_item(OP_SCAN, 4'h0);
    send_item(OP_SCAN, 4'ha);
    send_item(OP_SCAN, 4'h5);
    send_item(OP_SCAN, 4'h3);
    send_item(OP_SCAN, 4'hc);
    send_item(OP_READ, 4'ha);
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int min_keys);
    int n;
    int first_keys;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    first_keys    = keys_predicted;
    n = 0;
    while (n < RANDOM_ITEMS ||
           (keys_predicted - first_keys < min_keys && n < 4 * RANDOM_ITEMS)) begin
      if ($urandom_range(99) < READ_PCT) begin
        send_item(OP_READ, 4'($urandom));
      end else begin
        send_item(OP_SCAN, pick_rows());
      end
      n++;
    end
  endtask

  // output side: check each accepted result, then pick the next ready level
  always @(posedge clk) begin : result_check
    key_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result item with nothing pending");
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        if (column_drive !== want.column_drive) begin
          report_mismatch($sformatf("column_drive %h, want %h", column_drive,
                                    want.column_drive));
        end
        if (key_valid !== want.key_valid) begin
          report_mismatch($sformatf("key_valid %b, want %b", key_valid, want.key_valid));
        end
        if (key_index !== want.key_index) begin
          report_mismatch($sformatf("key_index %0d, want %0d", key_index, want.key_index));
        end
        if (key_char !== want.key_char) begin
          report_mismatch($sformatf("key_char %h, want %h", key_char, want.key_char));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_streak <= 0;
    end else begin
      idle_streak <= idle_streak + 1;
      if (idle_streak >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    clear_keypad_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 32;
    recv_idle_pct = 85;
    test_read_empty_ring();
    test_full_matrix_press();
    test_held_keys();
    test_release_bounce();

    test_random_traffic(32, 85, 0);
    test_random_traffic(85, 32, 0);
    test_random_traffic(0, 0, 16);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d items sent, %0d results checked", items_sent, results_seen);
    $display("%0d debounced keys read back, %0d reads of an empty ring",
             keys_predicted, empty_reads);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
